// ----- hdl/svbs_pkg.sv -----
// Shared types, constants and defaults for the sparse voxel block store.
package svbs_pkg;

  // Default sizes for the top-level parameters
  localparam int SVBS_BLOCK_EDGE       = 4;
  localparam int SVBS_GRID_EDGE_VOXELS = 32;
  localparam int SVBS_POOL_BLOCKS      = 64;

  // Entries in the queue between the front and back halves
  localparam int SVBS_QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Register reset values
  localparam logic signed [23:0] ORIGIN_RST       = 24'sd0;
  localparam logic [15:0]        INV_SCALE_RST    = 16'd256;
  localparam logic [31:0]        INITIAL_WORD_RST = 32'hBF80_0000;  // -1.0
  localparam logic [31:0]        ERROR_WORD_RST   = 32'h7FC0_0000;  // quiet NaN

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ORIGIN_X        = 3'd0,
    CFG_ORIGIN_Y        = 3'd1,
    CFG_ORIGIN_Z        = 3'd2,
    CFG_INV_VOXEL_SCALE = 3'd3,
    CFG_INITIAL_WORD    = 3'd4,
    CFG_ERROR_WORD      = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_OUTSIDE   = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_LOOK,
    BS_ACC
  } back_state_e;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic [15:0]        inv_voxel_scale;
    logic [31:0]        initial_word;
    logic [31:0]        error_word;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic [31:0]        write_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_word;
    status_e     status;
  } out_item_t;

endpackage

// ----- hdl/svbs_stream_if.sv -----
// Valid/ready stream interface carrying one item per handshake.
interface svbs_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/sparse_voxel_block_store.sv -----
// Top level of the sparse voxel block store: config registers, front, queue, back.
//
// Usage: item_in takes a read or write request (kind, Q15.8 point, write word);
// item_out returns one item per request (read word, status). Both are
// valid/ready streams; an item moves when valid and ready are high at a clock
// edge. Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i
// while the block is idle; writes to unused indexes are ignored.
// Path: five front stages map the point to a block key and voxel offset,
// then the item passes the queue; the back reads the directory, then the
// written bitmap and voxel word, and loads the output register.
// Steps: a hit into an existing block passes the back through a directory
// read, a bitmap/voxel read and a result step, and the next hit's directory
// read overlaps that result step; first-touch allocations, absent blocks and
// pool-full writes finish in the lookup step, and out-of-grid items in idle.
// Reset: config registers take their defaults, the pool is emptied, and the
// directory's NB^3 entries (512 at default sizes) are swept invalid one entry
// per cycle; item_in stays not ready until the sweep ends.
// Stall: the result waits in the output register while item_out.ready is low;
// the back and queue stall behind it while the front keeps taking items until
// the queue fills.
module sparse_voxel_block_store
  import svbs_pkg::*;
#(
  parameter int BLOCK_EDGE       = SVBS_BLOCK_EDGE,
  parameter int GRID_EDGE_VOXELS = SVBS_GRID_EDGE_VOXELS,
  parameter int POOL_BLOCKS      = SVBS_POOL_BLOCKS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  svbs_stream_if.sink            item_in,
  svbs_stream_if.source          item_out
);

  localparam int NB        = (GRID_EDGE_VOXELS + BLOCK_EDGE - 1) / BLOCK_EDGE;
  localparam int DIR_DEPTH = NB * NB * NB;
  localparam int DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int BV        = BLOCK_EDGE * BLOCK_EDGE * BLOCK_EDGE;
  localparam int OFF_W     = $clog2(BV);
  localparam int QW        = 34 + DIR_AW + OFF_W;   // kind, outside, key, offset, word

  cfg_t          cfg_q;
  logic          clearing;
  logic          fq_valid, fq_ready;
  logic [QW-1:0] fq_data;
  logic          bq_valid, bq_ready;
  logic [QW-1:0] bq_data;
  logic          out_valid;
  out_item_t     out_data;

  // Configuration registers; each write lands in one field
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x        <= ORIGIN_RST;
      cfg_q.origin_y        <= ORIGIN_RST;
      cfg_q.origin_z        <= ORIGIN_RST;
      cfg_q.inv_voxel_scale <= INV_SCALE_RST;
      cfg_q.initial_word    <= INITIAL_WORD_RST;
      cfg_q.error_word      <= ERROR_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ORIGIN_X:        cfg_q.origin_x        <= cfg_wdata_i[23:0];
        CFG_ORIGIN_Y:        cfg_q.origin_y        <= cfg_wdata_i[23:0];
        CFG_ORIGIN_Z:        cfg_q.origin_z        <= cfg_wdata_i[23:0];
        CFG_INV_VOXEL_SCALE: cfg_q.inv_voxel_scale <= cfg_wdata_i[15:0];
        CFG_INITIAL_WORD:    cfg_q.initial_word    <= cfg_wdata_i;
        CFG_ERROR_WORD:      cfg_q.error_word      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: coordinate math, grid check, key/offset split
  svbs_front #(
    .BLOCK_EDGE       (BLOCK_EDGE),
    .GRID_EDGE_VOXELS (GRID_EDGE_VOXELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clearing_i (clearing),
    .in_valid_i (item_in.valid),
    .in_ready_o (item_in.ready),
    .in_data_i  (item_in.data),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_data_o   (fq_data)
  );

  // Classified items wait here so either side can stall alone
  svbs_queue #(
    .WIDTH (QW),
    .DEPTH (SVBS_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_data)
  );

  // Back: directory, pool allocation, voxel store, result register
  svbs_back #(
    .BLOCK_EDGE       (BLOCK_EDGE),
    .GRID_EDGE_VOXELS (GRID_EDGE_VOXELS),
    .POOL_BLOCKS      (POOL_BLOCKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_o  (clearing),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_data_i    (bq_data),
    .out_valid_o (out_valid),
    .out_ready_i (item_out.ready),
    .out_data_o  (out_data)
  );

  assign item_out.valid = out_valid;
  assign item_out.data  = out_data;

endmodule

// ----- hdl/svbs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module svbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/svbs_front.sv -----
// Front half: maps a point to a voxel, checks the grid bound, splits key and offset.
module svbs_front
  import svbs_pkg::*;
#(
  parameter int BLOCK_EDGE       = SVBS_BLOCK_EDGE,
  parameter int GRID_EDGE_VOXELS = SVBS_GRID_EDGE_VOXELS,
  localparam int NB        = (GRID_EDGE_VOXELS + BLOCK_EDGE - 1) / BLOCK_EDGE,
  localparam int DIR_DEPTH = NB * NB * NB,
  localparam int DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1,
  localparam int BV        = BLOCK_EDGE * BLOCK_EDGE * BLOCK_EDGE,
  localparam int OFF_W     = $clog2(BV),
  localparam int QW        = 34 + DIR_AW + OFF_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          clearing_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_data_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output logic [QW-1:0] q_data_o
);

  localparam int IDX_W = $clog2(GRID_EDGE_VOXELS);
  localparam int RK    = IDX_W + 2;              // reciprocal fraction bits
  localparam int RECIP = (1 << RK) / BLOCK_EDGE;
  localparam int PW    = IDX_W + RK;
  localparam int RW    = IDX_W + 4;
  localparam int NB_W  = (NB > 1) ? $clog2(NB) : 1;
  localparam int BE_W  = $clog2(BLOCK_EDGE);
  localparam int RND_W = 26;

  logic       en;
  logic       accept;
  logic [4:0] stg_v_q;

  logic signed [23:0] coord [3];
  logic signed [23:0] org   [3];

  logic signed [24:0] diff_d [3];
  logic signed [24:0] diff_q [3];
  logic signed [41:0] prod_d [3];
  logic signed [41:0] prod_q [3];
  logic [IDX_W-1:0]   idx3_d [3];
  logic [IDX_W-1:0]   idx3_q [3];
  logic [2:0]         lane_out;
  logic [IDX_W-1:0]   q0_d   [3];
  logic [IDX_W-1:0]   q0_q   [3];
  logic [IDX_W-1:0]   idx4_q [3];
  logic [NB_W-1:0]    blk_d  [3];
  logic [NB_W-1:0]    blk_q  [3];
  logic [BE_W-1:0]    ofs_d  [3];
  logic [BE_W-1:0]    ofs_q  [3];

  kind_e       kind_q [5];
  logic [31:0] word_q [5];
  logic        out3_q, out4_q, out5_q;

  logic [DIR_AW-1:0] key;
  logic [OFF_W-1:0]  off;

  // whole pipe stalls only when the last stage cannot enter the queue
  assign en         = !stg_v_q[4] || q_ready_i;
  assign in_ready_o = en && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;

  assign coord[0] = in_data_i.coord_x;
  assign coord[1] = in_data_i.coord_y;
  assign coord[2] = in_data_i.coord_z;
  assign org[0]   = cfg_i.origin_x;
  assign org[1]   = cfg_i.origin_y;
  assign org[2]   = cfg_i.origin_z;

  always_comb begin
    logic        neg;
    logic [41:0] mag;
    logic [41:0] sum;
    logic [RND_W-1:0] rnd;
    logic [PW-1:0]    rp;
    logic [RW-1:0]    r0;
    logic             fix;
    for (int a = 0; a < 3; a++) begin
      // stage 1: offset from origin
      diff_d[a] = {coord[a][23], coord[a]} - {org[a][23], org[a]};
      // stage 2: scale, Q.16 product
      prod_d[a] = diff_q[a] * $signed({1'b0, cfg_i.inv_voxel_scale});
      // stage 3: round half away from zero, grid bound
      neg         = prod_q[a][41];
      mag         = neg ? 42'(-prod_q[a]) : 42'(prod_q[a]);
      sum         = mag + 42'h8000;
      rnd         = sum[41:16];
      lane_out[a] = (neg && (rnd != '0)) || (rnd >= RND_W'(GRID_EDGE_VOXELS));
      idx3_d[a]   = rnd[IDX_W-1:0];
      // stage 4: quotient estimate by reciprocal, may be one low
      rp      = PW'(idx3_q[a]) * PW'(RECIP);
      q0_d[a] = rp[RK +: IDX_W];
      // stage 5: one correction step
      r0       = RW'(idx4_q[a]) - RW'(q0_q[a]) * RW'(BLOCK_EDGE);
      fix      = (r0 >= RW'(BLOCK_EDGE));
      blk_d[a] = NB_W'(RW'(q0_q[a]) + RW'(fix));
      ofs_d[a] = fix ? BE_W'(r0 - RW'(BLOCK_EDGE)) : BE_W'(r0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else if (en) begin
      stg_v_q <= {stg_v_q[3:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        diff_q[a] <= diff_d[a];
        prod_q[a] <= prod_d[a];
        idx3_q[a] <= idx3_d[a];
        q0_q[a]   <= q0_d[a];
        idx4_q[a] <= idx3_q[a];
        blk_q[a]  <= blk_d[a];
        ofs_q[a]  <= ofs_d[a];
      end
      kind_q[0] <= in_data_i.kind;
      word_q[0] <= in_data_i.write_word;
      for (int s = 1; s < 5; s++) begin
        kind_q[s] <= kind_q[s-1];
        word_q[s] <= word_q[s-1];
      end
      out3_q <= |lane_out;
      out4_q <= out3_q;
      out5_q <= out4_q;
    end
  end

  assign key = DIR_AW'(blk_q[0])
             + DIR_AW'(blk_q[1]) * DIR_AW'(NB)
             + DIR_AW'(blk_q[2]) * DIR_AW'(NB * NB);
  assign off = OFF_W'(ofs_q[0])
             + OFF_W'(ofs_q[1]) * OFF_W'(BLOCK_EDGE)
             + OFF_W'(ofs_q[2]) * OFF_W'(BLOCK_EDGE * BLOCK_EDGE);

  assign q_valid_o = stg_v_q[4];
  assign q_data_o  = {kind_q[4], out5_q, key, off, word_q[4]};

endmodule

// ----- hdl/svbs_queue.sv -----
// Small register FIFO decoupling the front half from the back half.
module svbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/svbs_back.sv -----
// Back half: directory lookup, block allocation, voxel store access, result register.
module svbs_back
  import svbs_pkg::*;
#(
  parameter int BLOCK_EDGE       = SVBS_BLOCK_EDGE,
  parameter int GRID_EDGE_VOXELS = SVBS_GRID_EDGE_VOXELS,
  parameter int POOL_BLOCKS      = SVBS_POOL_BLOCKS,
  localparam int NB        = (GRID_EDGE_VOXELS + BLOCK_EDGE - 1) / BLOCK_EDGE,
  localparam int DIR_DEPTH = NB * NB * NB,
  localparam int DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1,
  localparam int BV        = BLOCK_EDGE * BLOCK_EDGE * BLOCK_EDGE,
  localparam int OFF_W     = $clog2(BV),
  localparam int QW        = 34 + DIR_AW + OFF_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  output logic          clearing_o,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  logic [QW-1:0] q_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_item_t     out_data_o
);

  localparam int SLOT_W   = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int FILL_W   = $clog2(POOL_BLOCKS + 1);
  localparam int VS_DEPTH = POOL_BLOCKS * BV;
  localparam int VS_AW    = (VS_DEPTH > 1) ? $clog2(VS_DEPTH) : 1;
  localparam int DE_W     = SLOT_W + 1;
  localparam int BMP_AW   = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;

  back_state_e state_q, state_d;

  // queue head
  kind_e             head_kind;
  logic              head_out;
  logic [DIR_AW-1:0] head_key;
  logic [OFF_W-1:0]  head_off;
  logic [31:0]       head_word;

  // item in flight
  kind_e             cur_kind_q;
  logic [DIR_AW-1:0] cur_key_q;
  logic [OFF_W-1:0]  cur_off_q;
  logic [31:0]       cur_word_q;
  logic [SLOT_W-1:0] slot_q;

  logic [DIR_AW-1:0] clr_q;
  logic [FILL_W-1:0] fill_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  // memory ports
  logic              dir_we, dir_re;
  logic [DIR_AW-1:0] dir_waddr;
  logic [DE_W-1:0]   dir_wdata, dir_rdata;
  logic              bmp_we, bmp_re;
  logic [BMP_AW-1:0] bmp_waddr, bmp_raddr;
  logic [BV-1:0]     bmp_wdata, bmp_rdata;
  logic              vox_we, vox_re;
  logic [VS_AW-1:0]  vox_waddr, vox_raddr;
  logic [31:0]       vox_rdata;

  logic              can_out, emit, take_cur, fill_inc;
  out_item_t         res;
  logic              de_valid;
  logic [SLOT_W-1:0] de_slot, fill_slot;
  logic              cur_write;
  logic              look_absent, look_full, look_alloc, look_done;
  logic [BV-1:0]     onehot;
  logic [VS_AW-1:0]  addr_alloc, addr_look, addr_acc;

  assign head_kind = kind_e'(q_data_i[QW-1]);
  assign {head_out, head_key, head_off, head_word} = q_data_i[QW-2:0];

  assign de_valid    = dir_rdata[DE_W-1];
  assign de_slot     = dir_rdata[SLOT_W-1:0];
  assign fill_slot   = SLOT_W'(fill_q);
  assign cur_write   = (cur_kind_q == KIND_WRITE);
  assign look_absent = !cur_write && !de_valid;
  assign look_full   = cur_write && !de_valid && (fill_q >= FILL_W'(POOL_BLOCKS));
  assign look_alloc  = cur_write && !de_valid && !look_full;
  assign look_done   = look_absent || look_full || look_alloc;
  assign can_out     = !out_valid_q || out_ready_i;
  assign onehot      = BV'(1) << cur_off_q;

  assign addr_alloc = VS_AW'(fill_slot) * VS_AW'(BV) + VS_AW'(cur_off_q);
  assign addr_look  = VS_AW'(de_slot) * VS_AW'(BV) + VS_AW'(cur_off_q);
  assign addr_acc   = VS_AW'(slot_q) * VS_AW'(BV) + VS_AW'(cur_off_q);

  assign clearing_o = (state_q == BS_CLEAR);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_CLEAR: begin
        if (clr_q == DIR_AW'(DIR_DEPTH - 1)) begin
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid_i && !head_out) begin
          state_d = BS_LOOK;
        end
      end
      BS_LOOK: begin
        if (!look_done) begin
          state_d = BS_ACC;
        end else if (can_out) begin
          state_d = BS_IDLE;
        end
      end
      BS_ACC: begin
        if (can_out) begin
          state_d = (q_valid_i && !head_out) ? BS_LOOK : BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // outputs: memory controls, queue pop, result
  always_comb begin
    q_ready_o = 1'b0;
    take_cur  = 1'b0;
    emit      = 1'b0;
    fill_inc  = 1'b0;
    res       = '{read_word: 32'd0, status: ST_OK};
    dir_we    = 1'b0;
    dir_waddr = cur_key_q;
    dir_wdata = '0;
    dir_re    = 1'b0;
    bmp_we    = 1'b0;
    bmp_waddr = BMP_AW'(slot_q);
    bmp_wdata = bmp_rdata | onehot;
    bmp_re    = 1'b0;
    bmp_raddr = BMP_AW'(de_slot);
    vox_we    = 1'b0;
    vox_waddr = addr_acc;
    vox_re    = 1'b0;
    vox_raddr = addr_look;
    case (state_q)
      BS_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = clr_q;
      end
      BS_IDLE: begin
        if (q_valid_i) begin
          if (head_out) begin
            if (can_out) begin
              q_ready_o     = 1'b1;
              emit          = 1'b1;
              res.read_word = (head_kind == KIND_WRITE) ? 32'd0 : cfg_i.error_word;
              res.status    = ST_OUTSIDE;
            end
          end else begin
            q_ready_o = 1'b1;
            take_cur  = 1'b1;
            dir_re    = 1'b1;
          end
        end
      end
      BS_LOOK: begin
        if (!look_done) begin
          bmp_re = 1'b1;
          vox_re = 1'b1;
        end else if (can_out) begin
          emit = 1'b1;
          if (look_absent) begin
            res.read_word = cfg_i.error_word;
            res.status    = ST_ABSENT;
          end else if (look_full) begin
            res.status = ST_POOL_FULL;
          end else begin
            // first touch: claim the next pool slot, fresh bitmap row
            fill_inc  = 1'b1;
            dir_we    = 1'b1;
            dir_wdata = {1'b1, fill_slot};
            bmp_we    = 1'b1;
            bmp_waddr = BMP_AW'(fill_slot);
            bmp_wdata = onehot;
            vox_we    = 1'b1;
            vox_waddr = addr_alloc;
          end
        end
      end
      BS_ACC: begin
        if (can_out) begin
          emit = 1'b1;
          if (cur_write) begin
            bmp_we = 1'b1;
            vox_we = 1'b1;
          end else begin
            res.read_word = bmp_rdata[cur_off_q] ? vox_rdata : cfg_i.initial_word;
          end
          if (q_valid_i && !head_out) begin
            q_ready_o = 1'b1;
            take_cur  = 1'b1;
            dir_re    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_CLEAR;
      clr_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BS_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (fill_inc) begin
        fill_q <= fill_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_cur) begin
      cur_kind_q <= head_kind;
      cur_key_q  <= head_key;
      cur_off_q  <= head_off;
      cur_word_q <= head_word;
    end
    if ((state_q == BS_LOOK) && !look_done) begin
      slot_q <= de_slot;
    end
    if (emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  svbs_ram #(.WIDTH(DE_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (dir_re),
    .raddr_i (head_key),
    .rdata_o (dir_rdata)
  );

  svbs_ram #(.WIDTH(BV), .DEPTH(POOL_BLOCKS)) u_bmp_ram (
    .clk_i   (clk_i),
    .we_i    (bmp_we),
    .waddr_i (bmp_waddr),
    .wdata_i (bmp_wdata),
    .re_i    (bmp_re),
    .raddr_i (bmp_raddr),
    .rdata_o (bmp_rdata)
  );

  svbs_ram #(.WIDTH(32), .DEPTH(VS_DEPTH)) u_vox_ram (
    .clk_i   (clk_i),
    .we_i    (vox_we),
    .waddr_i (vox_waddr),
    .wdata_i (cur_word_q),
    .re_i    (vox_re),
    .raddr_i (vox_raddr),
    .rdata_o (vox_rdata)
  );

endmodule
